// File: design/pvt_pkg.sv
package pvt_pkg;

    localparam int COORD_W = 16;
    localparam int TRAN_W = 17;
    localparam int PROD_W = 33;
    localparam int SUM_W = 35;
    localparam int SCR_W = 20;
    localparam int QUO_BITS = 21;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_ROW0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROW3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TRANSLATION = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_VIEWPORT = 3'd5;

    localparam logic [63:0] ROW0_RESET = 64'd4096;
    localparam logic [63:0] ROW1_RESET = 64'd268435456;
    localparam logic [63:0] ROW2_RESET = 64'd17592186044416;
    localparam logic [63:0] ROW3_RESET = 64'd1152921504606846976;
    localparam logic [47:0] TRANSLATION_RESET = 48'd1649267441664;
    localparam logic [23:0] VIEWPORT_RESET = 24'd286950;

    localparam logic signed [SUM_W-1:0] ONE_Q20 = 35'sd1048576;
    localparam logic signed [SCR_W-1:0] SCR_MAX = 20'sd524287;
    localparam logic signed [SCR_W-1:0] SCR_MIN = -20'sd524288;

    typedef struct packed {
        logic signed [15:0] vertex_x;
        logic signed [15:0] vertex_y;
        logic signed [15:0] vertex_z;
    } vertex_t;

    typedef struct packed {
        logic signed [19:0] screen_x;
        logic signed [19:0] screen_y;
        logic w_was_zero;
        logic clipped_range;
    } result_t;

    function automatic int col_of(input int c);
        return (c == 2) ? 3 : c;
    endfunction

endpackage

// File: design/pvt_div.sv
module pvt_div #(
    parameter int NUM_W = 52,
    parameter int DEN_W = 35
) (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  logic signed [NUM_W-1:0] num,
    input  logic signed [DEN_W-1:0] den,
    input  logic side_in,
    output logic out_valid,
    output logic signed [pvt_pkg::SCR_W-1:0] quo,
    output logic clip,
    output logic side_out
);
    import pvt_pkg::*;

    logic [NUM_W-1:0] nm_reg;
    logic [DEN_W-1:0] dm0_reg;
    logic neg0_reg, side0_reg, v0_reg;

    logic [NUM_W-1:0] rem_reg [QUO_BITS+1];
    logic [QUO_BITS-1:0] q_reg [QUO_BITS+1];
    logic [DEN_W-1:0] dm_reg [QUO_BITS+1];
    logic neg_reg [QUO_BITS+1];
    logic ovf_reg [QUO_BITS+1];
    logic side_reg [QUO_BITS+1];
    logic v_reg [QUO_BITS+1];

    logic signed [SCR_W-1:0] quo_reg, quo_next;
    logic clip_reg, clip_next, side_out_reg, out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        nm_reg <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
        dm0_reg <= den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
        neg0_reg <= num[NUM_W-1] ^ den[DEN_W-1];
        side0_reg <= side_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else
        begin
            v_reg[0] <= v0_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= nm_reg;
        q_reg[0] <= '0;
        dm_reg[0] <= dm0_reg;
        neg_reg[0] <= neg0_reg;
        ovf_reg[0] <= (nm_reg >> QUO_BITS) >= NUM_W'(dm0_reg);
        side_reg[0] <= side0_reg;
    end

    for (genvar s = 0; s < QUO_BITS; s++)
    begin : g_step
        localparam int SH = QUO_BITS - 1 - s;
        logic take;
        assign take = (rem_reg[s] >> SH) >= NUM_W'(dm_reg[s]);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[s+1] <= 1'b0;
            end
            else
            begin
                v_reg[s+1] <= v_reg[s];
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[s+1] <= take ? rem_reg[s] - (NUM_W'(dm_reg[s]) << SH) : rem_reg[s];
            q_reg[s+1] <= q_reg[s] | (QUO_BITS'(take) << SH);
            dm_reg[s+1] <= dm_reg[s];
            neg_reg[s+1] <= neg_reg[s];
            ovf_reg[s+1] <= ovf_reg[s];
            side_reg[s+1] <= side_reg[s];
        end
    end

    always_comb
    begin
        logic [QUO_BITS-1:0] mag;
        mag = q_reg[QUO_BITS];
        clip_next = 1'b0;
        quo_next = SCR_W'(mag);
        if (neg_reg[QUO_BITS])
        begin
            if (ovf_reg[QUO_BITS] || mag > QUO_BITS'(524288))
            begin
                clip_next = 1'b1;
                quo_next = SCR_MIN;
            end
            else
            begin
                quo_next = SCR_W'(-$signed({1'b0, mag}));
            end
        end
        else if (ovf_reg[QUO_BITS] || mag > QUO_BITS'(524287))
        begin
            clip_next = 1'b1;
            quo_next = SCR_MAX;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= v_reg[QUO_BITS];
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        clip_reg <= clip_next;
        side_out_reg <= side_reg[QUO_BITS];
    end

    assign out_valid = out_valid_reg;
    assign quo = quo_reg;
    assign clip = clip_reg;
    assign side_out = side_out_reg;

`ifndef SYNTHESIS
    a_valid_chain: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $past(v_reg[QUO_BITS]))
        else $error("divider valid out of step");
    a_clip_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && clip |-> quo == SCR_MAX || quo == SCR_MIN)
        else $error("clipped quotient not at a bound");
    a_ovf_clip: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[QUO_BITS] && ovf_reg[QUO_BITS] |=> clip)
        else $error("overflow not flagged");
`endif

endmodule

// File: design/perspective_vertex_transform.sv
// Channel   Direction  Handshake              Payload
// vertex    in         start, busy            vertex (x, y, z)
// result    out        result_valid strobe    result (screen x, y, flags)
// config    in         cfg_valid, cfg_ready   cfg_index, cfg_data
//
// One vertex is taken every cycle; busy stays low since the pipeline never stalls.
// A result is shown once its transfer has passed 5 transform stages and 24 divider stages.
// The divider retires one quotient bit per stage over 21 stages.
// Reset clears all valid bits and loads the identity matrix and default registers.
// Results are shown for one cycle; the receiver cannot stall them.
module perspective_vertex_transform #(
    parameter int VIEW_BITS = 12
) (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  pvt_pkg::vertex_t vertex,
    output logic result_valid,
    output pvt_pkg::result_t result,
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic [pvt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pvt_pkg::CFG_DATA_W-1:0] cfg_data
);
    import pvt_pkg::*;

    localparam int MUL_W = SUM_W + 2 + VIEW_BITS;
    localparam int NUM_W = MUL_W + 3;

    logic [63:0] mrow_reg [4];
    logic [47:0] translation_reg;
    logic [23:0] viewport_reg;
    logic [23:0] vp_shift;
    logic [VIEW_BITS-1:0] width, height;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic signed [TRAN_W-1:0] t_reg [3];
    logic signed [PROD_W-1:0] p_reg [3][3];
    logic signed [SUM_W-1:0] sum_reg [3];
    logic signed [SUM_W-1:0] den4_reg, den5_reg;
    logic signed [SUM_W:0] ax_reg, ay_reg;
    logic wz4_reg, wz5_reg;
    logic signed [NUM_W-1:0] nx_reg, ny_reg;

    logic dx_valid, dy_valid, dx_clip, dy_clip, dx_side, dy_side;
    logic signed [SCR_W-1:0] dx_quo, dy_quo;

    assign busy = 1'b0;
    assign cfg_ready = 1'b1;
    assign vp_shift = viewport_reg >> VIEW_BITS;
    assign width = viewport_reg[VIEW_BITS-1:0];
    assign height = vp_shift[VIEW_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mrow_reg[0] <= ROW0_RESET;
            mrow_reg[1] <= ROW1_RESET;
            mrow_reg[2] <= ROW2_RESET;
            mrow_reg[3] <= ROW3_RESET;
            translation_reg <= TRANSLATION_RESET;
            viewport_reg <= VIEWPORT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_ROW0: mrow_reg[0] <= cfg_data;
                REG_ROW1: mrow_reg[1] <= cfg_data;
                REG_ROW2: mrow_reg[2] <= cfg_data;
                REG_ROW3: mrow_reg[3] <= cfg_data;
                REG_TRANSLATION: translation_reg <= cfg_data[47:0];
                REG_VIEWPORT: viewport_reg <= cfg_data[23:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start && !busy;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg[0] <= TRAN_W'(vertex.vertex_x) + TRAN_W'($signed(translation_reg[15:0]));
        t_reg[1] <= TRAN_W'(vertex.vertex_y) + TRAN_W'($signed(translation_reg[31:16]));
        t_reg[2] <= TRAN_W'(vertex.vertex_z) + TRAN_W'($signed(translation_reg[47:32]));

        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                p_reg[r][c] <= PROD_W'(t_reg[r])
                    * PROD_W'($signed(mrow_reg[r][16*col_of(c) +: 16]));
            end
        end

        for (int c = 0; c < 3; c++)
        begin
            sum_reg[c] <= SUM_W'(p_reg[0][c]) + SUM_W'(p_reg[1][c]) + SUM_W'(p_reg[2][c])
                + (SUM_W'($signed(mrow_reg[3][16*col_of(c) +: 16])) <<< 8);
        end

        wz4_reg <= (sum_reg[2] == '0);
        den4_reg <= (sum_reg[2] == '0) ? ONE_Q20 : sum_reg[2];
        ax_reg <= (SUM_W+1)'(sum_reg[0])
            + (SUM_W+1)'((sum_reg[2] == '0) ? ONE_Q20 : sum_reg[2]);
        ay_reg <= (SUM_W+1)'(sum_reg[1])
            + (SUM_W+1)'((sum_reg[2] == '0) ? ONE_Q20 : sum_reg[2]);

        nx_reg <= {MUL_W'(ax_reg) * MUL_W'($signed({1'b0, width})), 3'b000};
        ny_reg <= {MUL_W'(ay_reg) * MUL_W'($signed({1'b0, height})), 3'b000};
        den5_reg <= den4_reg;
        wz5_reg <= wz4_reg;
    end

    pvt_div #(.NUM_W(NUM_W), .DEN_W(SUM_W)) u_div_x (
        .clk(clk), .rst_n(rst_n), .in_valid(v5_reg), .num(nx_reg), .den(den5_reg),
        .side_in(wz5_reg), .out_valid(dx_valid), .quo(dx_quo), .clip(dx_clip),
        .side_out(dx_side)
    );

    pvt_div #(.NUM_W(NUM_W), .DEN_W(SUM_W)) u_div_y (
        .clk(clk), .rst_n(rst_n), .in_valid(v5_reg), .num(ny_reg), .den(den5_reg),
        .side_in(wz5_reg), .out_valid(dy_valid), .quo(dy_quo), .clip(dy_clip),
        .side_out(dy_side)
    );

    assign result_valid = dx_valid;
    assign result.screen_x = dx_quo;
    assign result.screen_y = dy_quo;
    assign result.w_was_zero = dx_side;
    assign result.clipped_range = dx_clip | dy_clip;

`ifndef SYNTHESIS
    a_lanes_valid: assert property (@(posedge clk) disable iff (!rst_n)
        dx_valid == dy_valid)
        else $error("divider lanes out of step");
    a_lanes_flag: assert property (@(posedge clk) disable iff (!rst_n)
        dx_valid |-> dx_side == dy_side)
        else $error("zero-w flag differs between lanes");
    a_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg |-> $past(start))
        else $error("vertex stage filled without a transfer");
`endif

endmodule
